### design/gsp_pkg.sv
package gsp_pkg;

    // Default sizes
    localparam int HISTORY_BITS_DEF = 12;
    localparam int BTB_ENTRIES_DEF  = 256;

    // Item opcodes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Two-bit counter levels
    localparam logic [1:0] CTR_MIN        = 2'b00;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'b10;
    localparam logic [1:0] CTR_MAX        = 2'b11;

    // Fall-through step of one instruction
    localparam logic [31:0] PC_STEP = 32'd4;

    // Table clearing / refill sequencer
    typedef enum logic [1:0] {
        SWP_CLEAR_ALL,
        SWP_FILL,
        SWP_RUN
    } sweep_state_t;

endpackage

### design/gsp_mem.sv
module gsp_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/gshare_predictor_with_btb.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_op, s_pc, s_next_pc, s_taken
// m_        out        m_valid / m_ready      m_predicted_pc, m_predicted_taken
// cfg_      in         cfg_valid / cfg_ready  cfg_counter_init
//
// One item per cycle while s_ready is high, predict or update; m_valid rises from the
// output register after a predict item leaves stage 1. Counter and BTB entries sit in
// RAMs read at acceptance; an update writes back in the next cycle, forwarded to an
// item read at that same edge. After reset a clearing pass over all counter and BTB
// entries runs and a counter_init write refills all counters; s_ready is low
// during either pass and while a held prediction waits on m_ready.
module gshare_predictor_with_btb #(
    parameter int HISTORY_BITS = gsp_pkg::HISTORY_BITS_DEF,
    parameter int BTB_ENTRIES  = gsp_pkg::BTB_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_pc,
    input  logic [31:0] s_next_pc,
    input  logic        s_taken,
    // Prediction output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_predicted_pc,
    output logic        m_predicted_taken,
    // counter_init write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_counter_init
);

    localparam int PHT_SIZE   = 1 << HISTORY_BITS;
    localparam int BI_W       = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
    localparam int TAG_W      = 30 - BI_W;
    localparam int BE_W       = 1 + TAG_W + 32;
    localparam int SWEEP_LEN  = (PHT_SIZE > BTB_ENTRIES) ? PHT_SIZE : BTB_ENTRIES;
    localparam int SW_W       = $clog2(SWEEP_LEN);
    localparam logic [BI_W-1:0] BTB_MASK   = BI_W'(BTB_ENTRIES - 1);
    localparam logic [SW_W:0]   PHT_LIM    = (SW_W+1)'(PHT_SIZE);
    localparam logic [SW_W:0]   BTB_LIM    = (SW_W+1)'(BTB_ENTRIES);
    localparam logic [SW_W-1:0] SWEEP_LAST = SW_W'(SWEEP_LEN - 1);
    localparam logic [SW_W-1:0] PHT_LAST   = SW_W'(PHT_SIZE - 1);

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    gsp_pkg::sweep_state_t state_reg, state_next;
    logic [SW_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]              counter_init_reg;
    logic                    sweeping, sweep_last, pht_clr_en, btb_clr_en;
    logic                    cfg_fire;

    logic [HISTORY_BITS-1:0] hist_reg;
    logic                    s_fire;
    logic [HISTORY_BITS-1:0] s_pidx;
    logic [BI_W-1:0]         s_bidx;

    // stage 1: memory data is valid here
    logic                    v1_reg;
    logic                    op1_reg, taken1_reg;
    logic [31:0]             pc1_reg, npc1_reg;
    logic [HISTORY_BITS-1:0] pidx1_reg;
    logic [BI_W-1:0]         bidx1_reg;
    logic [TAG_W-1:0]        tag1_reg;
    logic                    pht_fwd_hit_reg, btb_fwd_hit_reg;
    logic [1:0]              pht_fwd_reg;
    logic [BE_W-1:0]         btb_fwd_reg;
    logic                    adv1;

    logic [1:0]              pht_rdata, ctr1, ctr_upd;
    logic [BE_W-1:0]         btb_rdata, btb1, btb_wentry;
    logic                    pht_we_item, btb_we_item;
    logic                    pht_we, btb_we;
    logic [HISTORY_BITS-1:0] pht_waddr;
    logic [1:0]              pht_wdata;
    logic [BI_W-1:0]         btb_waddr;
    logic [BE_W-1:0]         btb_wdata;

    logic                    pred_taken, btb_hit;
    logic [31:0]             pred_pc;

    logic                    m_valid_reg;
    logic [31:0]             m_pc_reg;
    logic                    m_taken_reg;

    // ------------------------------------------------------------------
    // Clearing / refill sequencer
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gsp_pkg::SWP_CLEAR_ALL: begin
                // a config write restarts the pass but keeps clearing the BTB
                if (!cfg_fire && sweep_last) state_next = gsp_pkg::SWP_RUN;
            end
            gsp_pkg::SWP_FILL: begin
                if (!cfg_fire && sweep_last) state_next = gsp_pkg::SWP_RUN;
            end
            gsp_pkg::SWP_RUN: begin
                if (cfg_fire) state_next = gsp_pkg::SWP_FILL;
            end
            default: state_next = gsp_pkg::SWP_CLEAR_ALL;
        endcase
    end

    always_comb begin
        sweeping   = (state_reg != gsp_pkg::SWP_RUN);
        sweep_last = (state_reg == gsp_pkg::SWP_CLEAR_ALL) ? (cnt_reg == SWEEP_LAST)
                                                           : (cnt_reg == PHT_LAST);
        pht_clr_en = sweeping && ({1'b0, cnt_reg} < PHT_LIM);
        btb_clr_en = (state_reg == gsp_pkg::SWP_CLEAR_ALL) && ({1'b0, cnt_reg} < BTB_LIM);
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_fire) begin
            cnt_next = '0;
        end else if (sweeping) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= gsp_pkg::SWP_CLEAR_ALL;
            cnt_reg          <= '0;
            counter_init_reg <= gsp_pkg::CTR_MIN;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_fire) begin
                counter_init_reg <= cfg_counter_init;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept and address generation
    // ------------------------------------------------------------------
    assign adv1    = !v1_reg || (op1_reg == gsp_pkg::OP_UPDATE) || !m_valid_reg || m_ready;
    assign s_ready = !sweeping && adv1;
    assign s_fire  = s_valid && s_ready;
    assign s_pidx  = s_pc[HISTORY_BITS+1:2] ^ hist_reg;
    assign s_bidx  = s_pc[BI_W+1:2] & BTB_MASK;

    // history shifts when an update is accepted, so the next item already sees it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (s_fire && (s_op == gsp_pkg::OP_UPDATE)) begin
            hist_reg <= HISTORY_BITS'({hist_reg, s_taken});
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 register, with forwarding of the write at the same edge
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_fire) begin
            v1_reg <= 1'b1;
        end else if (adv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op1_reg         <= s_op;
            taken1_reg      <= s_taken;
            pc1_reg         <= s_pc;
            npc1_reg        <= s_next_pc;
            pidx1_reg       <= s_pidx;
            bidx1_reg       <= s_bidx;
            tag1_reg        <= s_pc[31:BI_W+2];
            pht_fwd_hit_reg <= pht_we_item && (pidx1_reg == s_pidx);
            pht_fwd_reg     <= ctr_upd;
            btb_fwd_hit_reg <= btb_we_item && (bidx1_reg == s_bidx);
            btb_fwd_reg     <= btb_wentry;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    gsp_mem #(
        .DEPTH  (PHT_SIZE),
        .WIDTH  (2),
        .ADDR_W (HISTORY_BITS)
    ) u_pht (
        .aclk    (aclk),
        .wr_en   (pht_we),
        .wr_addr (pht_waddr),
        .wr_data (pht_wdata),
        .rd_en   (s_fire),
        .rd_addr (s_pidx),
        .rd_data (pht_rdata)
    );

    gsp_mem #(
        .DEPTH  (BTB_ENTRIES),
        .WIDTH  (BE_W),
        .ADDR_W (BI_W)
    ) u_btb (
        .aclk    (aclk),
        .wr_en   (btb_we),
        .wr_addr (btb_waddr),
        .wr_data (btb_wdata),
        .rd_en   (s_fire),
        .rd_addr (s_bidx),
        .rd_data (btb_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 compute: prediction and counter training
    // ------------------------------------------------------------------
    always_comb begin
        ctr1 = pht_fwd_hit_reg ? pht_fwd_reg : pht_rdata;
        btb1 = btb_fwd_hit_reg ? btb_fwd_reg : btb_rdata;

        // saturating counter step
        ctr_upd = ctr1;
        if (taken1_reg) begin
            if (ctr1 != gsp_pkg::CTR_MAX) ctr_upd = ctr1 + 2'd1;
        end else begin
            if (ctr1 != gsp_pkg::CTR_MIN) ctr_upd = ctr1 - 2'd1;
        end
        btb_wentry = {1'b1, tag1_reg, npc1_reg};

        // entry layout: valid, tag, target
        pred_taken = (ctr1 >= gsp_pkg::CTR_WEAK_TAKEN);
        btb_hit    = pred_taken && btb1[BE_W-1] && (btb1[BE_W-2:32] == tag1_reg);
        pred_pc    = btb_hit ? btb1[31:0] : (pc1_reg + gsp_pkg::PC_STEP);

        pht_we_item = v1_reg && (op1_reg == gsp_pkg::OP_UPDATE);
        btb_we_item = pht_we_item && taken1_reg;
    end

    // write ports: a clearing or refill write takes priority over an item write-back
    always_comb begin
        pht_we    = pht_clr_en || pht_we_item;
        pht_waddr = pht_clr_en ? cnt_reg[HISTORY_BITS-1:0] : pidx1_reg;
        pht_wdata = pht_clr_en ? counter_init_reg : ctr_upd;
        btb_we    = btb_clr_en || btb_we_item;
        btb_waddr = btb_clr_en ? cnt_reg[BI_W-1:0] : bidx1_reg;
        btb_wdata = btb_clr_en ? '0 : btb_wentry;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (v1_reg && (op1_reg == gsp_pkg::OP_PREDICT) && adv1) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && (op1_reg == gsp_pkg::OP_PREDICT) && adv1) begin
            m_pc_reg    <= pred_pc;
            m_taken_reg <= pred_taken;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_pc    = m_pc_reg;
    assign m_predicted_taken = m_taken_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HIST_W      = gsp_pkg::HISTORY_BITS_DEF;
    localparam int PHT_N       = 1 << HIST_W;
    localparam int BTB_N       = gsp_pkg::BTB_ENTRIES_DEF;
    localparam int TAG_SHIFT   = $clog2(BTB_N);
    localparam int TAG_W       = 30 - TAG_SHIFT;
    localparam int POOL_N      = 12;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 300000;

    // One predicted fetch address with its direction
    typedef struct packed {
        logic [31:0] fetch_pc;
        logic        taken;
    } fetch_guess_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = gsp_pkg::OP_PREDICT;
    logic [31:0] s_pc = '0;
    logic [31:0] s_next_pc = '0;
    logic        s_taken = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_predicted_pc;
    logic        m_predicted_taken;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_counter_init = gsp_pkg::CTR_MIN;

    // Shadow copy of the predictor state
    logic [HIST_W-1:0] ghist;
    logic [1:0]        pht     [0:PHT_N-1];
    bit                btb_vld [0:BTB_N-1];
    logic [TAG_W-1:0]  btb_tag [0:BTB_N-1];
    logic [31:0]       btb_tgt [0:BTB_N-1];

    fetch_guess_t pending_guesses[$];

    // Branch pool for the random traffic
    logic [31:0] pool_pc   [0:POOL_N-1];
    logic [31:0] pool_tgt  [0:POOL_N-1];
    int          pool_bias [0:POOL_N-1];

    bit throttle_on = 1'b1;
    int mismatch_cnt = 0;
    int items_sent = 0;
    int predictions_seen = 0;
    int settings_used = 0;
    int cycle_cnt = 0;

    gshare_predictor_with_btb dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_pc              (s_pc),
        .s_next_pc         (s_next_pc),
        .s_taken           (s_taken),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_predicted_pc    (m_predicted_pc),
        .m_predicted_taken (m_predicted_taken),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_counter_init  (cfg_counter_init)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Advance the shadow state by one item; returns 1 when a prediction comes out
    function automatic bit apply_branch_item(input logic op, input logic [31:0] pc,
                                             input logic [31:0] npc, input logic tkn,
                                             output fetch_guess_t guess);
        logic [29:0]      word;
        int               pidx;
        int               bidx;
        logic [TAG_W-1:0] tag;
        word  = pc[31:2];
        pidx  = int'(word[HIST_W-1:0] ^ ghist);
        bidx  = int'(word[TAG_SHIFT-1:0]);
        tag   = word[29:TAG_SHIFT];
        guess = '0;
        if (op == gsp_pkg::OP_PREDICT) begin
            guess.taken    = (pht[pidx] >= gsp_pkg::CTR_WEAK_TAKEN);
            guess.fetch_pc = pc + gsp_pkg::PC_STEP;
            // target only used on a taken guess with a tag hit
            if (guess.taken && btb_vld[bidx] && btb_tag[bidx] == tag)
                guess.fetch_pc = btb_tgt[bidx];
            return 1'b1;
        end
        // train with the old history, then shift the outcome in
        ghist = {ghist[HIST_W-2:0], tkn};
        if (tkn) begin
            if (pht[pidx] != gsp_pkg::CTR_MAX)
                pht[pidx] = pht[pidx] + 2'd1;
            btb_vld[bidx] = 1'b1;
            btb_tag[bidx] = tag;
            btb_tgt[bidx] = npc;
        end else begin
            if (pht[pidx] != gsp_pkg::CTR_MIN)
                pht[pidx] = pht[pidx] - 2'd1;
        end
        return 1'b0;
    endfunction

    // Present one item and wait for it to be taken; returns at a falling edge
    task automatic send_item(input logic op, input logic [31:0] pc,
                             input logic [31:0] npc, input logic tkn);
        int           gap;
        fetch_guess_t guess;
        gap = throttle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_pc      <= pc;
        s_next_pc <= npc;
        s_taken   <= tkn;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        if (apply_branch_item(op, pc, npc, tkn, guess))
            pending_guesses.push_back(guess);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding prediction and write-back finish
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_guesses.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Write counter_init; the block refills all counters afterwards
    task automatic set_counter_init(input logic [1:0] v);
        cfg_valid        <= 1'b1;
        cfg_counter_init <= v;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        for (int i = 0; i < PHT_N; i++)
            pht[i] = v;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per item, then compare with the oldest guess
    initial begin : result_checker
        int           stall;
        fetch_guess_t want;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = throttle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            predictions_seen++;
            if (pending_guesses.size() == 0) begin
                $display("%0t: unexpected prediction: expected none, got pc=%h taken=%b",
                         $time, m_predicted_pc, m_predicted_taken);
                mismatch_cnt++;
            end else begin
                want = pending_guesses.pop_front();
                if (m_predicted_pc !== want.fetch_pc) begin
                    $display("%0t: predicted_pc mismatch: expected %h, got %h",
                             $time, want.fetch_pc, m_predicted_pc);
                    mismatch_cnt++;
                end
                if (m_predicted_taken !== want.taken) begin
                    $display("%0t: predicted_taken mismatch: expected %b, got %b",
                             $time, want.taken, m_predicted_taken);
                    mismatch_cnt++;
                end
            end
            @(negedge aclk);
        end
    end

    // Cold tables: fall-through addresses, including the wrap past the top
    task automatic test_cold_predictions();
        throttle_on = 1'b1;
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_item(gsp_pkg::OP_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        send_item(gsp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 32'h5555_5555, 1'b1);
        drain_results();
    endtask

    // Counter held at zero by a not-taken update, then one step up
    task automatic test_counter_floor();
        throttle_on = 1'b0;
        send_item(gsp_pkg::OP_UPDATE, 32'h0000_0100, 32'hAAAA_AAAA, 1'b0);
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_0100, 32'h0, 1'b0);
        send_item(gsp_pkg::OP_UPDATE, 32'h0000_0100, 32'h0000_2000, 1'b1);
        // BTB now holds the entry but the counter is still weak
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_0100, 32'h0, 1'b0);
        drain_results();
    endtask

    // Saturated counters: BTB hits, tag misses and extreme targets
    task automatic test_btb_targets();
        throttle_on = 1'b1;
        set_counter_init(gsp_pkg::CTR_MAX);
        send_item(gsp_pkg::OP_UPDATE, 32'h0000_1237, 32'h8000_0000, 1'b1);
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_1234, 32'h0, 1'b0);
        // same BTB slot, different tag
        send_item(gsp_pkg::OP_PREDICT, 32'hABCD_1234, 32'h0, 1'b0);
        send_item(gsp_pkg::OP_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 1'b1);
        send_item(gsp_pkg::OP_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1);
        send_item(gsp_pkg::OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0);
        send_item(gsp_pkg::OP_UPDATE, 32'h0000_1234, 32'h1111_1111, 1'b0);
        send_item(gsp_pkg::OP_PREDICT, 32'h0000_1234, 32'h0, 1'b0);
        drain_results();
    endtask

    // Predict/update pairs over a small branch set, plus random noise items
    task automatic run_random_phase(input logic [1:0] init_val, input int n_items,
                                    input bit mid_pause);
        int  sent;
        int  k;
        int  next_flip;
        bit  paused;
        set_counter_init(init_val);
        for (int i = 0; i < POOL_N; i++) begin
            // some branches alias an earlier one in the BTB with another tag
            if (i > 0 && $urandom_range(0, 3) == 0)
                pool_pc[i] = {22'($urandom_range(0, 32'h3F_FFFF)), pool_pc[i-1][9:0]};
            else
                pool_pc[i] = $urandom;
            pool_tgt[i]  = $urandom;
            pool_bias[i] = $urandom_range(0, 2) * 45 + 5;
        end
        sent      = 0;
        next_flip = 0;
        paused    = 1'b0;
        while (sent < n_items) begin
            if (sent >= next_flip) begin
                throttle_on = ($urandom_range(0, 3) != 0);
                next_flip += 32;
            end
            if (mid_pause && !paused && sent >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, POOL_N - 1);
                send_item(gsp_pkg::OP_PREDICT, pool_pc[k], $urandom,
                          ($urandom_range(0, 1) == 1));
                if ($urandom_range(0, 15) == 0)
                    pool_tgt[k] = $urandom;
                send_item(gsp_pkg::OP_UPDATE, pool_pc[k], pool_tgt[k],
                          ($urandom_range(0, 99) < pool_bias[k]));
                sent += 2;
            end else begin
                send_item(($urandom_range(0, 1) == 1) ? gsp_pkg::OP_UPDATE
                                                      : gsp_pkg::OP_PREDICT,
                          $urandom, $urandom, ($urandom_range(0, 1) == 1));
                sent += 1;
            end
        end
        drain_results();
    endtask

    initial begin : test_sequence
        // shadow state after reset
        ghist = '0;
        for (int i = 0; i < PHT_N; i++)
            pht[i] = gsp_pkg::CTR_MIN;
        for (int i = 0; i < BTB_N; i++) begin
            btb_vld[i] = 1'b0;
            btb_tag[i] = '0;
            btb_tgt[i] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_cold_predictions();
        test_counter_floor();
        test_btb_targets();
        run_random_phase(2'd1, 110, 1'b0);
        run_random_phase(gsp_pkg::CTR_WEAK_TAKEN, 110, 1'b1);
        run_random_phase(gsp_pkg::CTR_MIN, 110, 1'b0);
        run_random_phase(gsp_pkg::CTR_MAX, 110, 1'b0);

        $display("Sent %0d branch items and checked %0d predictions", items_sent,
                 predictions_seen);
        $display("over %0d counter_init writes, with throttled and back-to-back traffic",
                 settings_used);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
